/* design/catmull_rom_point_eval_macros.svh */
// Assertion helpers for the Catmull-Rom point evaluator
`ifndef CATMULL_ROM_POINT_EVAL_MACROS_SVH
`define CATMULL_ROM_POINT_EVAL_MACROS_SVH

// Property that holds on every clock out of reset
`define CRPE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("crpe check failed");

// Implication checked on the same edge
`define CRPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crpe implication failed");

`endif

/* design/crpe_pkg.sv */
`timescale 1ns / 1ps
package crpe_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int T_FRAC     = 16;
    localparam int POS_W      = 24;
    localparam int K_W        = POS_W - T_FRAC;
    localparam int Q_W        = 20;
    localparam int PROD_W     = 32 + Q_W;
    localparam int ACC_W      = PROD_W + 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TOO_FEW = 2'd1,
        ST_RANGE   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TT,
        S_TTT,
        S_Q,
        S_MAC,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     append_wr;
        logic     ld_status;
        t_status  status;
        logic     calc_tt;
        logic     calc_ttt;
        logic     calc_q;
        logic     rd_en;
        logic [1:0] rd_idx;
        logic     mul_en;
        logic [1:0] mul_idx;
        logic     acc_clr;
        logic     acc_en;
        logic     ld_result;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic too_few;
        logic out_of_range;
    } t_dp_sts;

endpackage

/* design/crpe_in_if.sv */
`timescale 1ns / 1ps
interface crpe_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic [crpe_pkg::POS_W-1:0] position;

    modport source (output valid, command, in_x, in_y, in_z, position, input ready);
    modport sink   (input valid, command, in_x, in_y, in_z, position, output ready);
endinterface

/* design/crpe_out_if.sv */
`timescale 1ns / 1ps
interface crpe_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]  status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

/* design/crpe_datapath.sv */
`timescale 1ns / 1ps
module crpe_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  crpe_pkg::t_dp_cmd          i_cmd,
    input  logic signed [31:0]         i_x,
    input  logic signed [31:0]         i_y,
    input  logic signed [31:0]         i_z,
    input  logic [crpe_pkg::POS_W-1:0] i_position,
    output crpe_pkg::t_dp_sts          o_sts,
    output logic signed [31:0]         o_x,
    output logic signed [31:0]         o_y,
    output logic signed [31:0]         o_z,
    output logic [1:0]                 o_status
);

    localparam int AW = crpe_pkg::IDX_W;
    localparam int CW = crpe_pkg::CNT_W;
    localparam int QW = crpe_pkg::Q_W;
    localparam int PW = crpe_pkg::PROD_W;
    localparam int AC = crpe_pkg::ACC_W;
    localparam int TF = crpe_pkg::T_FRAC;
    localparam int KW = crpe_pkg::K_W;

    logic [95:0]         r_mem [crpe_pkg::MAX_POINTS];
    logic [95:0]         r_rdata;
    logic [CW-1:0]       r_count;
    logic [KW-1:0]       r_k;
    logic [TF-1:0]       r_frac;
    logic [TF-1:0]       r_tt;
    logic [TF-1:0]       r_ttt;
    logic signed [QW-1:0] r_q [4];
    logic signed [PW-1:0] r_prod [3];
    logic signed [AC-1:0] r_acc [3];
    logic signed [31:0]  r_ox, r_oy, r_oz;
    logic [1:0]          r_ost;

    logic [KW-1:0]       w_k_in;
    logic [CW+1:0]       w_last;
    logic [2*TF-1:0]     w_sq;
    logic [2*TF-1:0]     w_cu;
    logic signed [QW-1:0] w_f, w_tt, w_ttt;
    logic [AW-1:0]       w_addr;
    logic signed [QW-1:0] w_qsel;
    logic signed [31:0]  w_res [3];

    // round to nearest (ties up), floor shift, saturate
    function automatic logic signed [31:0] f_finish(input logic signed [AC-1:0] a);
        logic signed [AC-1:0] rnd;
        logic signed [AC-1:0] sh;
        begin
            rnd = a + (AC'(1) <<< TF);
            sh  = rnd >>> (TF + 1);
            if (sh > $signed(AC'(32'h7fff_ffff))) begin
                f_finish = 32'sh7fff_ffff;
            end else if (sh < -$signed(AC'(33'h0_8000_0000))) begin
                f_finish = 32'sh8000_0000;
            end else begin
                f_finish = sh[31:0];
            end
        end
    endfunction

    // status of the item on the input side
    assign w_k_in = i_position[crpe_pkg::POS_W-1:TF];
    assign w_last = {{(CW+2-KW){1'b0}}, w_k_in} + (CW+2)'(3);
    assign o_sts.full         = (r_count == CW'(crpe_pkg::MAX_POINTS));
    assign o_sts.too_few      = (r_count < CW'(4));
    assign o_sts.out_of_range = (w_last >= {2'b00, r_count});

    // weight terms
    assign w_sq  = r_frac * r_frac;
    assign w_cu  = r_tt * r_frac;
    assign w_f   = $signed({{(QW-TF){1'b0}}, r_frac});
    assign w_tt  = $signed({{(QW-TF){1'b0}}, r_tt});
    assign w_ttt = $signed({{(QW-TF){1'b0}}, r_ttt});

    assign w_addr = r_k[AW-1:0] + {{(AW-2){1'b0}}, i_cmd.rd_idx};
    assign w_qsel = r_q[i_cmd.mul_idx];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_res[c] = f_finish(r_acc[c]);
        end
    end

    // point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.append_wr) begin
            r_count <= r_count + CW'(1);
        end
    end

    // point store, single port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_wr) begin
            r_mem[r_count[AW-1:0]] <= {i_z, i_y, i_x};
        end else if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // weights, products, accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_k    <= w_k_in;
            r_frac <= i_position[TF-1:0];
        end
        if (i_cmd.calc_tt) begin
            r_tt <= w_sq[2*TF-1:TF];
        end
        if (i_cmd.calc_ttt) begin
            r_ttt <= w_cu[2*TF-1:TF];
        end
        if (i_cmd.calc_q) begin
            r_q[0] <= w_tt + w_tt - w_ttt - w_f;
            r_q[1] <= w_ttt + w_ttt + w_ttt - (w_tt <<< 2) - w_tt
                      + (QW'(2) <<< TF);
            r_q[2] <= (w_tt <<< 2) + w_f - w_ttt - w_ttt - w_ttt;
            r_q[3] <= w_ttt - w_tt;
        end
        if (i_cmd.mul_en) begin
            r_prod[0] <= $signed(r_rdata[31:0])  * w_qsel;
            r_prod[1] <= $signed(r_rdata[63:32]) * w_qsel;
            r_prod[2] <= $signed(r_rdata[95:64]) * w_qsel;
        end
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.acc_clr) begin
                r_acc[c] <= '0;
            end else if (i_cmd.acc_en) begin
                r_acc[c] <= r_acc[c] + {{(AC-PW){r_prod[c][PW-1]}}, r_prod[c]};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_status) begin
            r_ox  <= '0;
            r_oy  <= '0;
            r_oz  <= '0;
            r_ost <= i_cmd.status;
        end else if (i_cmd.ld_result) begin
            r_ox  <= w_res[0];
            r_oy  <= w_res[1];
            r_oz  <= w_res[2];
            r_ost <= crpe_pkg::ST_OK;
        end
    end

    assign o_x      = r_ox;
    assign o_y      = r_oy;
    assign o_z      = r_oz;
    assign o_status = r_ost;

endmodule

/* design/crpe_ctrl.sv */
`timescale 1ns / 1ps
module crpe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_eval,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  crpe_pkg::t_dp_sts  i_sts,
    output crpe_pkg::t_dp_cmd  o_cmd,
    output crpe_pkg::t_state   o_state
);

    crpe_pkg::t_state r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic             r_out_v, n_out_v;
    logic             w_out_free;
    logic             w_in_fire;

    assign w_out_free = !r_out_v || i_out_ready;
    assign o_in_ready = (r_state == crpe_pkg::S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crpe_pkg::S_IDLE;
            r_step  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_out_v <= n_out_v;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.status = crpe_pkg::ST_OK;
        case (r_state)
            crpe_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    o_cmd.load_in = 1'b1;
                    if (!i_in_eval) begin
                        o_cmd.ld_status = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.status = crpe_pkg::ST_FULL;
                        end else begin
                            o_cmd.append_wr = 1'b1;
                        end
                    end else if (i_sts.too_few) begin
                        o_cmd.ld_status = 1'b1;
                        o_cmd.status    = crpe_pkg::ST_TOO_FEW;
                    end else if (i_sts.out_of_range) begin
                        o_cmd.ld_status = 1'b1;
                        o_cmd.status    = crpe_pkg::ST_RANGE;
                    end else begin
                        n_state = crpe_pkg::S_TT;
                    end
                end
            end
            crpe_pkg::S_TT: begin
                o_cmd.calc_tt = 1'b1;
                n_state = crpe_pkg::S_TTT;
            end
            crpe_pkg::S_TTT: begin
                o_cmd.calc_ttt = 1'b1;
                n_state = crpe_pkg::S_Q;
            end
            crpe_pkg::S_Q: begin
                o_cmd.calc_q  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_step  = '0;
                n_state = crpe_pkg::S_MAC;
            end
            crpe_pkg::S_MAC: begin
                // read point j, multiply point j-1, accumulate point j-2
                o_cmd.rd_en   = (r_step < 3'd4);
                o_cmd.rd_idx  = r_step[1:0];
                o_cmd.mul_en  = (r_step >= 3'd1) && (r_step <= 3'd4);
                o_cmd.mul_idx = 2'(r_step - 3'd1);
                o_cmd.acc_en  = (r_step >= 3'd2);
                if (r_step == 3'd5) begin
                    n_state = crpe_pkg::S_FIN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            crpe_pkg::S_FIN: begin
                if (w_out_free) begin
                    o_cmd.ld_result = 1'b1;
                    n_state = crpe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crpe_pkg::S_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        n_out_v = r_out_v && !i_out_ready;
        if (o_cmd.ld_status || o_cmd.ld_result) begin
            n_out_v = 1'b1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_state     = r_state;

endmodule

/* design/catmull_rom_point_eval.sv */
`timescale 1ns / 1ps
// Catmull-Rom point evaluator. Append beats (command 0) store one Q16.16 point
// in a 256-entry single-port store; evaluate beats (command 1) blend points k..k+3
// with cubic weights of the Q8.16 position's fraction; return saturated x, y, z.
// Every input beat yields one result beat. An append (refused when the store is
// full) or a rejected evaluate (too few points, segment past the end) has its
// result registered and valid in the cycle after it is taken. A good evaluate
// occupies the block from accept to result: two dependent weight multiplies, a
// step to form the weights, and six steps that read the four points through the
// one store port and multiply-accumulate them, then rounding. A new beat is taken
// while the previous result still waits, as long as it can leave this cycle.
`include "catmull_rom_point_eval_macros.svh"
module catmull_rom_point_eval (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crpe_in_if.sink   i_in,
    crpe_out_if.source o_out
);

    crpe_pkg::t_dp_cmd w_cmd;
    crpe_pkg::t_dp_sts w_sts;
    crpe_pkg::t_state  w_state;

    crpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_eval   (i_in.command),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    crpe_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_x        (i_in.in_x),
        .i_y        (i_in.in_y),
        .i_z        (i_in.in_z),
        .i_position (i_in.position),
        .o_sts      (w_sts),
        .o_x        (o_out.out_x),
        .o_y        (o_out.out_y),
        .o_z        (o_out.out_z),
        .o_status   (o_out.status)
    );

    // no input beat while an evaluate is in flight
    `CRPE_ASSERT_IMP(a_busy_no_accept, w_state != crpe_pkg::S_IDLE, !i_in.ready)
    // only ok results carry coordinates
    `CRPE_ASSERT_IMP(a_zero_on_error, o_out.valid && o_out.status != crpe_pkg::ST_OK,
        o_out.out_x == 32'sd0 && o_out.out_y == 32'sd0 && o_out.out_z == 32'sd0)
    // result register is never overwritten while it holds an untaken beat
    `CRPE_ASSERT_IMP(a_no_overwrite, o_out.valid && !o_out.ready,
        !w_cmd.ld_status && !w_cmd.ld_result)

endmodule
